// File: hdl/hbu_pkg.sv
package hbu_pkg;

  // Image and bank geometry. The image is split into four banks by row and
  // column parity, so the four neighbors of any vertex sit in four banks.
  localparam int MAX_SIDE   = 257;
  localparam int BANK_SIDE  = (MAX_SIDE + 1) / 2;
  localparam int BANK_DEPTH = BANK_SIDE * BANK_SIDE;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int HALF_W     = $clog2(BANK_SIDE);
  localparam int COORD_W    = 9;
  localparam int VERT_W     = 11;
  localparam int PIX_W      = 8;

  // Arithmetic widths.
  localparam int TOP_W   = 10;
  localparam int NUM_W   = 12;
  localparam int SCALE_W = 32;
  localparam int PROD_W  = NUM_W + SCALE_W;
  localparam int X_W     = PROD_W - 4;
  localparam int Q_W     = 32;
  localparam int HGT_W   = 33;

  localparam int NUM_STAGES = 8;

  localparam logic [HGT_W-1:0] ONE_Q16 = HGT_W'(65536);

  // Input kinds carried on tuser.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_IMAGE_SIDE   = 2'd0;
  localparam logic [1:0] REG_HEIGHT_SCALE = 2'd1;
  localparam logic [1:0] REG_INVERT       = 2'd2;

  localparam logic [COORD_W-1:0] SIDE_RESET  = COORD_W'(129);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

  // Address of a pixel inside its bank, from the halved row and column.
  function automatic logic [BANK_AW-1:0] bank_addr(input logic [HALF_W-1:0] rh,
                                                   input logic [HALF_W-1:0] ch);
    bank_addr = BANK_AW'(rh) * BANK_AW'(BANK_SIDE) + BANK_AW'(ch);
  endfunction

endpackage

// File: hdl/hbu_ram.sv
module hbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/heightmap_bilinear_upsampler.sv
// Bilinear x4 heightmap upsampler.
//
// The input stream carries one command per beat. tuser selects the kind:
// a pixel write stores pixel_value at (pixel_row, pixel_col), a query asks
// for the height at vertex (vertex_x, vertex_y) of the grid upsampled four
// times. Every input beat produces exactly one output beat, in order: the
// Q16.16 height in tdata and an out-of-range flag in tuser. Writes and
// out-of-range commands return height 0.
//
// The pipeline has eight register stages, the output register the last.
// One beat is accepted per cycle, back to back, until a stalled output
// has filled every stage; the four pixel banks let all four neighbors of a
// vertex be read in the same cycle. When the output receiver stalls, the
// stages fill up behind the output register and tready drops only once
// every stage holds a beat.
//
// Reset clears the pipeline and loads the register defaults (side 129,
// scale 1.0, no inversion). Pixel memory is not cleared; every pixel that a
// query touches must have been written first. The user must write registers
// over the APB port only while the stream is idle; the block does not enforce it.
module heightmap_bilinear_upsampler (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Bits from the lowest up: pixel_row[8:0], pixel_col[17:9],
  // pixel_value[25:18], vertex_x[36:26], vertex_y[47:37].
  input  logic [47:0] s_axis_tdata,
  // Bit 0: cmd.
  input  logic        s_axis_tuser,
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Bits from the lowest up: height[32:0] (signed), zero fill [39:33].
  output logic [39:0] m_axis_tdata,
  // Bit 0: status.
  output logic        m_axis_tuser,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NS = hbu_pkg::NUM_STAGES;

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  logic [hbu_pkg::COORD_W-1:0] image_side;
  logic [hbu_pkg::SCALE_W-1:0] height_scale;
  logic                        invert_heights;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_side     <= hbu_pkg::SIDE_RESET;
      height_scale   <= hbu_pkg::SCALE_RESET;
      invert_heights <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        hbu_pkg::REG_IMAGE_SIDE:   image_side     <= pwdata[hbu_pkg::COORD_W-1:0];
        hbu_pkg::REG_HEIGHT_SCALE: height_scale   <= pwdata;
        hbu_pkg::REG_INVERT:       invert_heights <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      hbu_pkg::REG_IMAGE_SIDE:   prdata = 32'(image_side);
      hbu_pkg::REG_HEIGHT_SCALE: prdata = height_scale;
      hbu_pkg::REG_INVERT:       prdata = 32'(invert_heights);
      default:                   prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control. A stage loads when it is empty or when the
  // stage after it loads; the output register is the last stage.
  // ---------------------------------------------------------------------
  logic [NS:1]   vld;
  logic [NS+1:1] en;
  logic [NS:1]   vld_in;

  always_comb begin
    en[NS+1] = m_axis_tready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  assign vld_in        = {vld[NS-1:1], s_axis_tvalid};
  assign s_axis_tready = en[1];
  assign m_axis_tvalid = vld[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Decode of the incoming beat.
  // ---------------------------------------------------------------------
  logic [hbu_pkg::COORD_W-1:0] pix_row, pix_col;
  logic [hbu_pkg::PIX_W-1:0]   pix_val;
  logic [hbu_pkg::VERT_W-1:0]  vx, vy, vmax;
  logic [hbu_pkg::COORD_W-1:0] side_eff, side_m1;
  logic [hbu_pkg::COORD_W-1:0] c1, c2, r1, r2;
  logic [1:0]                  fx, fy;
  logic                        wr_ok, q_ok, in_acc;

  assign pix_row = s_axis_tdata[8:0];
  assign pix_col = s_axis_tdata[17:9];
  assign pix_val = s_axis_tdata[25:18];
  assign vx      = s_axis_tdata[36:26];
  assign vy      = s_axis_tdata[47:37];

  // A side beyond the store saturates to the store's side.
  assign side_eff = (image_side > hbu_pkg::COORD_W'(hbu_pkg::MAX_SIDE)) ?
                    hbu_pkg::COORD_W'(hbu_pkg::MAX_SIDE) : image_side;
  assign side_m1  = side_eff - hbu_pkg::COORD_W'(1);
  assign vmax     = {side_eff, 2'b00};

  assign wr_ok = (pix_row < side_eff) && (pix_col < side_eff);
  assign q_ok  = (vx < vmax) && (vy < vmax);

  assign fx = vx[1:0];
  assign fy = vy[1:0];
  assign c1 = vx[hbu_pkg::VERT_W-1:2];
  assign r1 = vy[hbu_pkg::VERT_W-1:2];
  // The second neighbor clamps at the last row and column.
  assign c2 = (c1 == side_m1) ? c1 : c1 + hbu_pkg::COORD_W'(1);
  assign r2 = (r1 == side_m1) ? r1 : r1 + hbu_pkg::COORD_W'(1);

  assign in_acc = s_axis_tvalid & s_axis_tready;

  // ---------------------------------------------------------------------
  // Pixel banks. Bank index is {row parity, column parity}.
  // ---------------------------------------------------------------------
  logic [hbu_pkg::COORD_W-1:0] row_of_par [2];
  logic [hbu_pkg::COORD_W-1:0] col_of_par [2];
  logic [hbu_pkg::BANK_AW-1:0] rd_addr [4];
  logic [hbu_pkg::BANK_AW-1:0] wr_addr;
  logic [1:0]                  wr_bank;
  logic [3:0]                  ram_we;
  logic                        ram_re;
  logic [hbu_pkg::PIX_W-1:0]   rd_data [4];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      row_of_par[p] = (r1[0] == 1'(p)) ? r1 : r2;
      col_of_par[p] = (c1[0] == 1'(p)) ? c1 : c2;
    end
    for (int b = 0; b < 4; b++) begin
      rd_addr[b] = hbu_pkg::bank_addr(row_of_par[b/2][hbu_pkg::COORD_W-1:1],
                                      col_of_par[b%2][hbu_pkg::COORD_W-1:1]);
    end
  end

  assign wr_addr = hbu_pkg::bank_addr(pix_row[hbu_pkg::COORD_W-1:1],
                                      pix_col[hbu_pkg::COORD_W-1:1]);
  assign wr_bank = {pix_row[0], pix_col[0]};
  assign ram_re  = in_acc && (s_axis_tuser == hbu_pkg::CMD_QUERY) && q_ok;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      ram_we[b] = in_acc && (s_axis_tuser == hbu_pkg::CMD_WRITE) && wr_ok &&
                  (wr_bank == 2'(b));
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    hbu_ram #(
      .WIDTH(hbu_pkg::PIX_W),
      .DEPTH(hbu_pkg::BANK_DEPTH)
    ) u_bank (
      .clk  (clk),
      .we   (ram_we[b]),
      .waddr(wr_addr),
      .wdata(pix_val),
      .re   (ram_re),
      .raddr(rd_addr[b]),
      .rdata(rd_data[b])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 1: bank reads in flight. okq marks a query whose height counts.
  // ---------------------------------------------------------------------
  logic       s1_okq, s1_err;
  logic [1:0] s1_fx, s1_fy;
  logic       s1_r1p, s1_r2p, s1_c1p, s1_c2p;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_okq <= (s_axis_tuser == hbu_pkg::CMD_QUERY) && q_ok;
      s1_err <= (s_axis_tuser == hbu_pkg::CMD_QUERY) ? ~q_ok : ~wr_ok;
      s1_fx  <= fx;
      s1_fy  <= fy;
      s1_r1p <= r1[0];
      s1_r2p <= r2[0];
      s1_c1p <= c1[0];
      s1_c2p <= c2[0];
    end
  end

  // Stage 2: horizontal blend of the top and bottom pixel pairs.
  logic [hbu_pkg::PIX_W-1:0] p11, p12, p21, p22;
  logic [2:0]                wx0;
  logic [hbu_pkg::TOP_W-1:0] s2_top, s2_bot;
  logic [1:0]                s2_fy;
  logic                      s2_okq, s2_err;

  assign p11 = rd_data[{s1_r1p, s1_c1p}];
  assign p12 = rd_data[{s1_r1p, s1_c2p}];
  assign p21 = rd_data[{s1_r2p, s1_c1p}];
  assign p22 = rd_data[{s1_r2p, s1_c2p}];
  assign wx0 = 3'd4 - 3'(s1_fx);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_top <= hbu_pkg::TOP_W'(wx0) * hbu_pkg::TOP_W'(p11) +
                hbu_pkg::TOP_W'(s1_fx) * hbu_pkg::TOP_W'(p12);
      s2_bot <= hbu_pkg::TOP_W'(wx0) * hbu_pkg::TOP_W'(p21) +
                hbu_pkg::TOP_W'(s1_fx) * hbu_pkg::TOP_W'(p22);
      s2_fy  <= s1_fy;
      s2_okq <= s1_okq;
      s2_err <= s1_err;
    end
  end

  // Stage 3: vertical blend, in sixteenths of a pixel level.
  logic [2:0]                wy0;
  logic [hbu_pkg::NUM_W-1:0] s3_num;
  logic                      s3_okq, s3_err;

  assign wy0 = 3'd4 - 3'(s2_fy);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_num <= hbu_pkg::NUM_W'(wy0) * hbu_pkg::NUM_W'(s2_top) +
                hbu_pkg::NUM_W'(s2_fy) * hbu_pkg::NUM_W'(s2_bot);
      s3_okq <= s2_okq;
      s3_err <= s2_err;
    end
  end

  // Stage 4: scale multiply (12 x 32 bits).
  logic [hbu_pkg::PROD_W-1:0] s4_prod;
  logic                       s4_okq, s4_err;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_prod <= hbu_pkg::PROD_W'(s3_num) * hbu_pkg::PROD_W'(height_scale);
      s4_okq  <= s3_okq;
      s4_err  <= s3_err;
    end
  end

  // Stages 5 to 7 divide by 4080 = 16 * 255. The divide by 16 is a shift;
  // x / 255 is estimated as (x + x/2^8 + ... + x/2^32) / 2^8, which is low
  // by at most one, and then corrected from the remainder.
  logic [hbu_pkg::X_W-1:0] x5;
  logic [hbu_pkg::X_W:0]   s5_a;
  logic [hbu_pkg::X_W:0]   s5_b;
  logic [hbu_pkg::X_W-1:0] s5_x;
  logic                    s5_okq, s5_err;

  assign x5 = s4_prod[hbu_pkg::PROD_W-1:4];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_a   <= (hbu_pkg::X_W+1)'(x5) + (hbu_pkg::X_W+1)'(x5 >> 8) +
                (hbu_pkg::X_W+1)'(x5 >> 16);
      s5_b   <= (hbu_pkg::X_W+1)'(x5 >> 24) + (hbu_pkg::X_W+1)'(x5 >> 32);
      s5_x   <= x5;
      s5_okq <= s4_okq;
      s5_err <= s4_err;
    end
  end

  logic [hbu_pkg::X_W:0]   sum6;
  logic [hbu_pkg::Q_W-1:0] s6_q0;
  logic [hbu_pkg::X_W-1:0] s6_x;
  logic                    s6_okq, s6_err;

  assign sum6 = s5_a + s5_b;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_q0  <= sum6[hbu_pkg::Q_W+7:8];
      s6_x   <= s5_x;
      s6_okq <= s5_okq;
      s6_err <= s5_err;
    end
  end

  logic [hbu_pkg::X_W-1:0] rem7;
  logic [hbu_pkg::Q_W-1:0] s7_q;
  logic                    s7_okq, s7_err;

  assign rem7 = s6_x - (({8'd0, s6_q0} << 8) - hbu_pkg::X_W'(s6_q0));

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_q   <= s6_q0 + hbu_pkg::Q_W'(rem7 >= hbu_pkg::X_W'(255));
      s7_okq <= s6_okq;
      s7_err <= s6_err;
    end
  end

  // Stage 8: output register, with inversion and zero height for writes
  // and out-of-range commands.
  logic [hbu_pkg::HGT_W-1:0] h8;
  logic [hbu_pkg::HGT_W-1:0] s8_height;
  logic                      s8_status;

  assign h8 = invert_heights ? hbu_pkg::ONE_Q16 - {1'b0, s7_q} : {1'b0, s7_q};

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_height <= s7_okq ? h8 : '0;
      s8_status <= s7_err;
    end
  end

  assign m_axis_tdata = {7'd0, s8_height};
  assign m_axis_tuser = s8_status;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_one_bank_written: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ram_we))
    else $error("more than one pixel bank written in one cycle");

  a_no_read_with_write: assert property (@(posedge clk) disable iff (rst)
    !((|ram_we) && ram_re))
    else $error("bank read and bank write issued together");

  a_read_fills_stage1: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> (vld[1] && s1_okq))
    else $error("bank read launched without a valid query behind it");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled while the output register is empty");

  a_flagged_height_zero: assert property (@(posedge clk) disable iff (rst)
    (vld[NS] && s8_status) |-> (s8_height == '0))
    else $error("out-of-range result carries a nonzero height");

endmodule

// File: verif/heightmap_result_checker.sv
module heightmap_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Full weight sum: 16 quarter-step units times the top pixel level.
  localparam longint unsigned FULL_SCALE_NUM = 4080;

  typedef struct packed {
    logic [hbu_pkg::HGT_W-1:0] height;
    logic                      status;
  } height_status_t;

  height_status_t              expected_heights[$];
  logic [hbu_pkg::PIX_W-1:0]   image_mem [hbu_pkg::MAX_SIDE*hbu_pkg::MAX_SIDE];
  logic [hbu_pkg::COORD_W-1:0] side_reg = hbu_pkg::SIDE_RESET;
  logic [hbu_pkg::SCALE_W-1:0] scale_reg = hbu_pkg::SCALE_RESET;
  logic                        invert_reg = 1'b0;
  int                          mismatches = 0;
  int                          outstanding = 0;
  int                          result_index = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  function automatic int unsigned active_side();
    return (32'(side_reg) > hbu_pkg::MAX_SIDE) ? hbu_pkg::MAX_SIDE : 32'(side_reg);
  endfunction

  // Applies one command to the image copy and works out the result beat.
  function automatic height_status_t apply_command(input logic cmd,
                                                   input logic [47:0] data);
    int unsigned       s, row, col, vx, vy, fx, fy, c1, r1, c2, r2, upper, lower;
    longint unsigned   num, h;
    height_status_t    res;
    res = '0;
    s   = active_side();
    row = 32'(data[8:0]);
    col = 32'(data[17:9]);
    vx  = 32'(data[36:26]);
    vy  = 32'(data[47:37]);
    if (cmd == hbu_pkg::CMD_WRITE) begin
      if (row < s && col < s) begin
        image_mem[row*hbu_pkg::MAX_SIDE + col] = data[25:18];
      end else begin
        res.status = 1'b1;
      end
    end else if (vx >= 4*s || vy >= 4*s) begin
      res.status = 1'b1;
    end else begin
      fx = vx % 4;
      fy = vy % 4;
      c1 = vx / 4;
      r1 = vy / 4;
      c2 = (c1 + 1 < s) ? c1 + 1 : s - 1;
      r2 = (r1 + 1 < s) ? r1 + 1 : s - 1;
      upper = (4 - fx) * 32'(image_mem[r1*hbu_pkg::MAX_SIDE + c1]) +
              fx * 32'(image_mem[r1*hbu_pkg::MAX_SIDE + c2]);
      lower = (4 - fx) * 32'(image_mem[r2*hbu_pkg::MAX_SIDE + c1]) +
              fx * 32'(image_mem[r2*hbu_pkg::MAX_SIDE + c2]);
      num   = 64'((4 - fy) * upper + fy * lower);
      h     = (num * 64'(scale_reg)) / FULL_SCALE_NUM;
      res.height = invert_reg ? hbu_pkg::HGT_W'(64'(hbu_pkg::ONE_Q16) - h) :
                                hbu_pkg::HGT_W'(h);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [hbu_pkg::HGT_W-1:0] want,
                                 input logic [hbu_pkg::HGT_W-1:0] got);
    $display("result beat %0d: %s expected %0h, got %0h", result_index, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    height_status_t want, got;
    if (rst) begin
      side_reg   = hbu_pkg::SIDE_RESET;
      scale_reg  = hbu_pkg::SCALE_RESET;
      invert_reg = 1'b0;
      expected_heights.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          hbu_pkg::REG_IMAGE_SIDE:   side_reg = pwdata[hbu_pkg::COORD_W-1:0];
          hbu_pkg::REG_HEIGHT_SCALE: scale_reg = pwdata;
          hbu_pkg::REG_INVERT:       invert_reg = pwdata[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_heights.push_back(apply_command(s_axis_tuser, s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.height = m_axis_tdata[hbu_pkg::HGT_W-1:0];
        got.status = m_axis_tuser;
        if (expected_heights.size() == 0) begin
          report_mismatch("unrequested beat, height", '0, got.height);
        end else begin
          want = expected_heights.pop_front();
          if (got.height !== want.height) report_mismatch("height", want.height, got.height);
          if (got.status !== want.status) begin
            report_mismatch("status", hbu_pkg::HGT_W'(want.status),
                            hbu_pkg::HGT_W'(got.status));
          end
        end
        result_index++;
      end
    end
    outstanding <= expected_heights.size();
  end

endmodule

// File: verif/heightmap_bilinear_upsampler_test.sv
module heightmap_bilinear_upsampler_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Stimulus stops once this many input beats have gone in.
  localparam int ITEM_TARGET  = 1150;
  // The pipeline is eight stages deep; the drain pause leaves some slack.
  localparam int DRAIN_CYCLES = 16;
  // The long receiver stall, well past the depth of the pipeline.
  localparam int HOLD_CYCLES  = 300;
  // The limit is many times what a run of over a thousand beats with
  // idling and stalls needs.
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // Bits from the lowest up: pixel_row[8:0], pixel_col[17:9],
  // pixel_value[25:18], vertex_x[36:26], vertex_y[47:37].
  logic [47:0] s_axis_tdata = '0;
  // Bit 0: cmd.
  logic        s_axis_tuser = hbu_pkg::CMD_WRITE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // Bits from the lowest up: height[32:0] (signed), zero fill [39:33].
  logic [39:0] m_axis_tdata;
  // Bit 0: status.
  logic        m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int beats_sent = 0;
  int cycle_count = 0;

  // The side register as last written, to know which pixels and vertices
  // are in range.
  logic [hbu_pkg::COORD_W-1:0] side_reg = hbu_pkg::SIDE_RESET;
  // Pixels written since reset. A query is only sent once all four of its
  // neighbors are marked here, since pixel memory starts out undefined.
  bit written [hbu_pkg::MAX_SIDE*hbu_pkg::MAX_SIDE];
  // Steady mode turns off idling on both sides.
  bit steady = 1'b0;
  // Asks the receiver for one long stall.
  bit hold_req = 1'b0;

  always #10 clk = ~clk;

  heightmap_bilinear_upsampler i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  heightmap_result_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  function automatic int unsigned active_side();
    return (32'(side_reg) > hbu_pkg::MAX_SIDE) ? hbu_pkg::MAX_SIDE : 32'(side_reg);
  endfunction

  // A vertex inside the upsampled grid of side s, now and then hugging the
  // last row or column so that the neighbor clamp gets exercised.
  function automatic int unsigned pick_vertex(input int unsigned s);
    if ($urandom_range(7) == 0) begin
      return 4*s - 1 - $urandom_range(0, (4*s > 8) ? 7 : 4*s - 1);
    end
    return $urandom_range(0, 4*s - 1);
  endfunction

  // Offers one beat and returns at the clock edge that accepts it. The valid
  // stays high on return; the next call either keeps it high or opens a gap.
  task automatic send_beat(input logic cmd, input logic [47:0] data);
    if (!steady && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    beats_sent++;
  endtask

  // Fields that a command does not use carry random bits.
  task automatic send_write(input int unsigned row, input int unsigned col,
                            input int unsigned value);
    int unsigned s;
    s = active_side();
    send_beat(hbu_pkg::CMD_WRITE,
              {11'($urandom), 11'($urandom), 8'(value), 9'(col), 9'(row)});
    if (row < s && col < s) written[row*hbu_pkg::MAX_SIDE + col] = 1'b1;
  endtask

  task automatic fill_pixel(input int unsigned row, input int unsigned col);
    if (!written[row*hbu_pkg::MAX_SIDE + col]) send_write(row, col, $urandom_range(0, 255));
  endtask

  // An in-range query first loads any of its four neighbors that were never
  // written, the clamped ones included, even where their weight is zero.
  task automatic send_query(input int unsigned vx, input int unsigned vy);
    int unsigned s, c1, r1, c2, r2;
    s = active_side();
    if (vx < 4*s && vy < 4*s) begin
      c1 = vx / 4;
      r1 = vy / 4;
      c2 = (c1 + 1 < s) ? c1 + 1 : s - 1;
      r2 = (r1 + 1 < s) ? r1 + 1 : s - 1;
      fill_pixel(r1, c1);
      fill_pixel(r1, c2);
      fill_pixel(r2, c1);
      fill_pixel(r2, c2);
    end
    send_beat(hbu_pkg::CMD_QUERY,
              {11'(vy), 11'(vx), 8'($urandom), 9'($urandom), 9'($urandom)});
  endtask

  // One APB write: a setup cycle, then an access cycle that completes at the
  // edge where pready is seen high.
  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drops valid and waits until every expected result has come back, then
  // lets the pipeline settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Registers change only with the stream idle. Unused register bits carry
  // random values, which the block has to drop.
  task automatic configure(input logic [hbu_pkg::COORD_W-1:0] side, input logic [31:0] scale,
                           input logic invert);
    wait_drained();
    write_register(hbu_pkg::REG_IMAGE_SIDE, ($urandom() & 32'hFFFF_FE00) | 32'(side));
    write_register(hbu_pkg::REG_HEIGHT_SCALE, scale);
    write_register(hbu_pkg::REG_INVERT, ($urandom() & 32'hFFFF_FFFE) | 32'(invert));
    side_reg = side;
  endtask

  // Mostly valid queries and writes with random content, the rest
  // out-of-range commands and fully random noise.
  task automatic random_beats(input int count);
    int          goal, pick;
    int unsigned s;
    goal = beats_sent + count;
    while (beats_sent < goal) begin
      s    = active_side();
      pick = $urandom_range(99);
      if (pick < 55 && s > 0) begin
        send_query(pick_vertex(s), pick_vertex(s));
      end else if (pick < 75 && s > 0) begin
        send_write($urandom_range(0, s - 1), $urandom_range(0, s - 1), $urandom_range(0, 255));
      end else if (pick < 85) begin
        if ($urandom_range(1)) begin
          send_write($urandom_range(s, 511), $urandom_range(0, 511), $urandom_range(0, 255));
        end else begin
          send_write($urandom_range(0, 511), $urandom_range(s, 511), $urandom_range(0, 255));
        end
      end else if (pick < 95) begin
        if ($urandom_range(1)) begin
          send_query($urandom_range(4*s, 2047), $urandom_range(0, 2047));
        end else begin
          send_query($urandom_range(0, 2047), $urandom_range(4*s, 2047));
        end
      end else if ($urandom_range(1)) begin
        send_write($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 255));
      end else begin
        send_query($urandom_range(0, 2047), $urandom_range(0, 2047));
      end
    end
  endtask

  // Receiver: random stalls, none in steady mode, and one long hold-off on
  // request, counted here while the sender keeps offering beats.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 18);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [hbu_pkg::COORD_W-1:0] side;
    logic [31:0]                 scale;
    int                          pick;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part on an 8 by 8 image at unit scale: pixel extremes, the
    // clamp at the last row and column, and out-of-range writes and queries
    // with every coordinate bit set.
    configure(9'd8, hbu_pkg::SCALE_RESET, 1'b0);
    send_write(0, 0, 255);
    send_write(0, 1, 0);
    send_write(1, 0, 128);
    send_write(1, 1, 255);
    send_write(6, 6, 17);
    send_write(6, 7, 255);
    send_write(7, 6, 0);
    send_write(7, 7, 200);
    send_write(8, 0, 99);
    send_write(0, 8, 99);
    send_write(511, 511, 255);
    send_query(0, 0);
    send_query(1, 2);
    send_query(3, 3);
    send_query(2, 1);
    send_query(31, 31);
    send_query(29, 30);
    send_query(27, 26);
    send_query(32, 0);
    send_query(0, 32);
    send_query(2047, 2047);

    // Extreme settings: a one-pixel image at full scale, side zero with
    // everything out of range, zero scale inverted, and an oversized side
    // that saturates to the largest image.
    configure(9'd1, 32'hFFFF_FFFF, 1'b0);
    random_beats(40);
    configure(9'd0, 32'h0001_2345, 1'b1);
    random_beats(30);
    configure(9'd2, 32'h0000_0000, 1'b1);
    random_beats(40);
    configure(9'd511, 32'hFFFF_FFFF, 1'b1);
    random_beats(60);
    configure(9'd257, hbu_pkg::SCALE_RESET, 1'b0);
    random_beats(60);

    // The receiver stalls long enough for the pipeline to fill and push
    // back on the input, while beats keep being offered.
    configure(9'd4, 32'h0003_0000, 1'b1);
    hold_req = 1'b1;
    random_beats(60);

    // A long stretch with no idling on either side.
    configure(9'd6, $urandom(), 1'b0);
    steady = 1'b1;
    random_beats(150);
    steady = 1'b0;

    // The sender pauses in mid-run until every result is back.
    configure(9'd10, hbu_pkg::SCALE_RESET, 1'b1);
    random_beats(30);
    wait_drained();
    random_beats(30);

    // Random settings, mostly small images with a few large ones.
    while (beats_sent < ITEM_TARGET) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        side = hbu_pkg::COORD_W'($urandom_range(2, 12));
      end else if (pick == 7) begin
        side = hbu_pkg::COORD_W'($urandom_range(0, 1));
      end else begin
        side = hbu_pkg::COORD_W'($urandom_range(13, 511));
      end
      pick = $urandom_range(7);
      if (pick == 0) begin
        scale = 32'h0000_0000;
      end else if (pick < 3) begin
        scale = 32'hFFFF_FFFF;
      end else begin
        scale = $urandom();
      end
      configure(side, scale, 1'($urandom_range(1)));
      random_beats($urandom_range(40, 100));
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/hbu_pkg.sv
hdl/hbu_ram.sv
hdl/heightmap_bilinear_upsampler.sv
verif/heightmap_result_checker.sv
verif/heightmap_bilinear_upsampler_test.sv
